// File: hdl/mbd_pkg.sv
// ----------------------------------------------------------------------------
// mbd_pkg
// Shared constants for the 2x2 box-filter mipmap downsampler.
// ----------------------------------------------------------------------------
package mbd_pkg;

  localparam int CFG_W       = 12;
  localparam int CFG_INDEX_W = 4;

  localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_WIDTH  = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_HEIGHT = CFG_INDEX_W'(1);

  localparam logic [CFG_W-1:0] SOURCE_WIDTH_RST  = CFG_W'(2048);
  localparam logic [CFG_W-1:0] SOURCE_HEIGHT_RST = CFG_W'(2048);

  localparam int NUM_CH = 4;

endpackage

// File: hdl/mipmap_box_downsample.sv
// ----------------------------------------------------------------------------
// mipmap_box_downsample
// 2x2 box-filter downsampler for RGBA raster streams; one output pixel per
// 2x2 block, odd last column or row dropped.
// ----------------------------------------------------------------------------
//  channel  dir  handshake           payload
//  s_*      in   s_tvalid/s_tready   s_tdata: red, green, blue, alpha
//  m_*      out  m_tvalid/m_tready   m_tdata: out_red..out_alpha, m_tlast
//  cfg_*    in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// One source pixel per cycle while s_tready is high. A result is registered
// first by the line store read and sum stage, then by the output register.
// Reset clears counters and sets both dimensions to 2048; the line store is
// not cleared. With m_tready low, one more result waits in the sum stage,
// then s_tready drops until the output register drains.
// ----------------------------------------------------------------------------
module mipmap_box_downsample #(
  parameter int MAX_WIDTH    = 2048,
  parameter int MAX_HEIGHT   = 2048,
  parameter int CHANNEL_BITS = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // red, green, blue, alpha
  input  logic [(4*CHANNEL_BITS+7)/8*8-1:0] s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // out_red, out_green, out_blue, out_alpha
  output logic [(4*CHANNEL_BITS+7)/8*8-1:0] m_tdata,
  // last_pixel
  output logic                            m_tlast,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mbd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mbd_pkg::CFG_W-1:0]       cfg_data
);

  localparam int CB         = CHANNEL_BITS;
  localparam int NCH        = mbd_pkg::NUM_CH;
  localparam int DATA_W     = (4*CHANNEL_BITS+7)/8*8;
  localparam int PS_W       = CB + 1;
  localparam int LINE_W     = NCH * PS_W;
  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int SLOT_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int COL_W      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W      = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int DW_A       = $clog2(MAX_WIDTH + 1);
  localparam int DW_B       = $clog2(MAX_HEIGHT + 1);
  localparam int DW_C       = (DW_A > DW_B) ? DW_A : DW_B;
  localparam int DIM_W      = ((DW_C > mbd_pkg::CFG_W) ? DW_C : mbd_pkg::CFG_W) + 1;

  logic [mbd_pkg::CFG_W-1:0] source_width;
  logic [mbd_pkg::CFG_W-1:0] source_height;
  logic [COL_W-1:0]          col;
  logic [ROW_W-1:0]          row;
  logic [CB-1:0]             left_pixel [NCH];

  logic [LINE_W-1:0]         line_mem [LINE_DEPTH];
  logic [LINE_W-1:0]         line_rdata;

  logic                      s1_valid;
  logic [LINE_W-1:0]         s1_pair;
  logic                      s1_last;

  logic [DIM_W-1:0]          w_eff, h_eff, out_w, out_h;
  logic [DIM_W-1:0]          slot_x, half_row;
  logic [SLOT_W-1:0]         slot;
  logic                      s_accept, cfg_accept, cfg_hit;
  logic                      slot_ok, row_ok, wr_en, rd_en, s1_go, last_next;
  logic                      col_wrap, row_wrap;
  logic [CB-1:0]             px [NCH];
  logic [LINE_W-1:0]         pair_flat;
  logic [DATA_W-1:0]         out_data;

  always_comb begin
    w_eff = DIM_W'(source_width);
    h_eff = DIM_W'(source_height);
    if (source_width == '0) begin
      w_eff = DIM_W'(1);
    end else if (DIM_W'(source_width) > DIM_W'(MAX_WIDTH)) begin
      w_eff = DIM_W'(MAX_WIDTH);
    end
    if (source_height == '0) begin
      h_eff = DIM_W'(1);
    end else if (DIM_W'(source_height) > DIM_W'(MAX_HEIGHT)) begin
      h_eff = DIM_W'(MAX_HEIGHT);
    end
  end

  assign out_w    = w_eff >> 1;
  assign out_h    = h_eff >> 1;
  assign slot     = SLOT_W'(col >> 1);
  assign slot_x   = DIM_W'(col >> 1);
  assign half_row = DIM_W'(row >> 1);
  assign slot_ok  = slot_x < out_w;
  assign row_ok   = half_row < out_h;
  assign col_wrap = (DIM_W'(col) + DIM_W'(1)) >= w_eff;
  assign row_wrap = (DIM_W'(row) + DIM_W'(1)) >= h_eff;
  assign last_next = (slot_x == out_w - DIM_W'(1)) && (half_row == out_h - DIM_W'(1));

  assign cfg_ready  = 1'b1;
  assign cfg_accept = cfg_valid && cfg_ready;
  assign cfg_hit    = cfg_accept &&
                      (cfg_index == mbd_pkg::REG_SOURCE_WIDTH ||
                       cfg_index == mbd_pkg::REG_SOURCE_HEIGHT);

  assign s1_go    = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || s1_go;
  assign s_accept = s_tvalid && s_tready;
  assign wr_en    = s_accept && col[0] && slot_ok && !row[0];
  assign rd_en    = s_accept && col[0] && slot_ok && row[0] && row_ok;

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      px[c] = s_tdata[c*CB +: CB];
      pair_flat[c*PS_W +: PS_W] = PS_W'(left_pixel[c]) + PS_W'(px[c]);
    end
  end

  always_comb begin
    out_data = '0;
    for (int c = 0; c < NCH; c++) begin
      out_data[c*CB +: CB] = CB'((CB+2)'(line_rdata[c*PS_W +: PS_W]) +
                                 (CB+2)'(s1_pair[c*PS_W +: PS_W]) >> 2);
    end
  end

  // config and raster counters
  always_ff @(posedge clk) begin
    if (rst) begin
      source_width  <= mbd_pkg::SOURCE_WIDTH_RST;
      source_height <= mbd_pkg::SOURCE_HEIGHT_RST;
      col           <= '0;
      row           <= '0;
    end else if (cfg_hit) begin
      if (cfg_index == mbd_pkg::REG_SOURCE_WIDTH) begin
        source_width <= cfg_data;
      end else begin
        source_height <= cfg_data;
      end
      col <= '0;
      row <= '0;
    end else if (s_accept) begin
      if (col_wrap) begin
        col <= '0;
        row <= row_wrap ? '0 : row + ROW_W'(1);
      end else begin
        col <= col + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NCH; c++) begin
        left_pixel[c] <= '0;
      end
    end else if (s_accept && !col[0]) begin
      for (int c = 0; c < NCH; c++) begin
        left_pixel[c] <= px[c];
      end
    end
  end

  // line store of pair sums
  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_mem[slot] <= pair_flat;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      line_rdata <= line_mem[slot];
    end
  end

  // sum stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= rd_en || (s1_valid && !s1_go);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      s1_pair <= pair_flat;
      s1_last <= last_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_go) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      m_tdata <= out_data;
      m_tlast <= s1_last;
    end
  end

  a_rd_fills_s1: assert property (@(posedge clk) disable iff (rst)
    rd_en |=> s1_valid)
    else $error("line read did not load sum stage");

  a_full_blocks_in: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && m_tvalid && !m_tready) |-> !s_tready)
    else $error("input taken with both stages full");

  a_cfg_restart: assert property (@(posedge clk) disable iff (rst)
    cfg_hit |=> (col == '0 && row == '0))
    else $error("register write did not restart frame");

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    (DIM_W'(col) < w_eff) && (DIM_W'(row) < h_eff))
    else $error("raster counter out of range");

endmodule

// File: test/mipmap_box_downsample_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mipmap_box_downsample_tb
// Streams RGBA pixels through the 2x2 box downsampler and checks every
// output pixel and its last flag against an in-bench predictor. Covers
// reset dimensions, zero and oversize dimensions, odd edges, frame
// restart on a register write, frame wrap, random backpressure on both
// sides and a long output stall that fills the block.
// ----------------------------------------------------------------------------
module mipmap_box_downsample_tb;

  localparam int MAX_DIM     = 2048;
  localparam int LINE_SLOTS  = MAX_DIM / 2;
  localparam int LATENCY_PAD = 8;
  localparam int STALL_LIMIT = 5000;
  localparam int LONG_HOLD   = 300;
  localparam int TOTAL_PX    = 1300;
  localparam int REG_BITS    = mbd_pkg::CFG_W;
  localparam int IDX_BITS    = mbd_pkg::CFG_INDEX_W;
  localparam logic [IDX_BITS-1:0] REG_NONE = '1;

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgba_t;

  typedef struct packed {
    logic  last;
    rgba_t px;
  } box_avg_t;

  logic                clk;
  logic                rst       = 1'b1;
  logic                s_tvalid  = 1'b0;
  logic                s_tready;
  logic [31:0]         s_tdata   = '0;
  logic                m_tvalid;
  logic                m_tready  = 1'b0;
  logic [31:0]         m_tdata;
  logic                m_tlast;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [IDX_BITS-1:0] cfg_index = '0;
  logic [REG_BITS-1:0] cfg_data  = '0;

  // predictor state
  logic [REG_BITS-1:0] width_reg  = mbd_pkg::SOURCE_WIDTH_RST;
  logic [REG_BITS-1:0] height_reg = mbd_pkg::SOURCE_HEIGHT_RST;
  int                  col_q      = 0;
  int                  row_q      = 0;
  rgba_t               left_px    = '0;
  logic [35:0]         pair_line [LINE_SLOTS];

  box_avg_t pending_avgs [$];
  rgba_t    pixel_q [$];
  int       pushed_px      = 0;
  int       accepted_px    = 0;
  int       src_idle_pct   = 0;
  int       sink_idle_pct  = 0;
  int       err_count      = 0;
  bit       long_hold_req  = 0;
  bit       long_hold_done = 0;
  int       hold_left      = 0;
  int       stuck_cycles   = 0;

  mipmap_box_downsample uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int eff_dim(logic [REG_BITS-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return int'(v);
  endfunction

  task automatic predict_box_avg(input rgba_t px);
    int         w;
    int         h;
    int         slot;
    int         c;
    logic [9:0] sum;
    box_avg_t   res;
    res  = '0;
    w    = eff_dim(width_reg);
    h    = eff_dim(height_reg);
    slot = col_q >> 1;
    if (col_q % 2 == 0) begin
      left_px = px;
    end else if (slot < w / 2) begin
      if (row_q % 2 == 0) begin
        for (c = 0; c < mbd_pkg::NUM_CH; c++)
          pair_line[slot][9*c +: 9] = 9'(left_px[8*c +: 8]) + 9'(px[8*c +: 8]);
      end else if (row_q / 2 < h / 2) begin
        for (c = 0; c < mbd_pkg::NUM_CH; c++) begin
          sum = 10'(pair_line[slot][9*c +: 9]) + 10'(left_px[8*c +: 8]) +
                10'(px[8*c +: 8]);
          res.px[8*c +: 8] = sum[9:2];
        end
        res.last = (slot == w / 2 - 1) && (row_q / 2 == h / 2 - 1);
        pending_avgs.push_back(res);
      end
    end
    if (col_q + 1 >= w) begin
      col_q = 0;
      row_q = (row_q + 1 >= h) ? 0 : row_q + 1;
    end else begin
      col_q++;
    end
  endtask

  // pixel driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_box_avg(rgba_t'(s_tdata));
        accepted_px++;
      end
      if (!s_tvalid || s_tready) begin
        if (pixel_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          s_tdata  <= pixel_q.pop_front();
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : result_check
    box_avg_t got;
    box_avg_t want;
    int       c;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.px   = rgba_t'(m_tdata);
        got.last = m_tlast;
        if (pending_avgs.size() == 0) begin
          $display("%0t: unexpected pixel expected none actual %h last %b",
                   $time, got.px, got.last);
          err_count++;
        end else begin
          want = pending_avgs.pop_front();
          for (c = 0; c < mbd_pkg::NUM_CH; c++)
            if (got.px[8*c +: 8] !== want.px[8*c +: 8]) begin
              $display("%0t: channel %0d expected %0d actual %0d", $time, c,
                       want.px[8*c +: 8], got.px[8*c +: 8]);
              err_count++;
            end
          if (got.last !== want.last) begin
            $display("%0t: last expected %b actual %b", $time, want.last, got.last);
            err_count++;
          end
        end
      end
      if (hold_left > 0) begin
        m_tready  <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (long_hold_req && !long_hold_done) begin
        m_tready       <= 1'b0;
        hold_left      <= LONG_HOLD;
        long_hold_done <= 1'b1;
      end else begin
        m_tready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // watchdog on cycles with no request accepted anywhere
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  task automatic write_reg(input logic [IDX_BITS-1:0] idx,
                           input logic [REG_BITS-1:0] val);
    @(posedge clk);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == mbd_pkg::REG_SOURCE_WIDTH) begin
      width_reg = val;
      col_q     = 0;
      row_q     = 0;
    end else if (idx == mbd_pkg::REG_SOURCE_HEIGHT) begin
      height_reg = val;
      col_q      = 0;
      row_q      = 0;
    end
  endtask

  task automatic queue_pixel(input rgba_t px);
    pixel_q.push_back(px);
    pushed_px++;
  endtask

  function automatic rgba_t rand_pixel();
    rgba_t p;
    int    c;
    p = $urandom;
    for (c = 0; c < mbd_pkg::NUM_CH; c++)
      case ($urandom_range(7))
        0:       p[8*c +: 8] = 8'h00;
        1:       p[8*c +: 8] = 8'hff;
        default: ;
      endcase
    return p;
  endfunction

  // all pixels taken, all results seen, then let the pipeline empty
  task automatic wait_idle();
    while (accepted_px != pushed_px || pending_avgs.size() != 0) @(posedge clk);
    repeat (LATENCY_PAD) @(posedge clk);
  endtask

  task automatic run_image(input int w, input int h, input int n, input int idle);
    write_reg(mbd_pkg::REG_SOURCE_WIDTH, REG_BITS'(w));
    write_reg(mbd_pkg::REG_SOURCE_HEIGHT, REG_BITS'(h));
    src_idle_pct  = idle;
    sink_idle_pct = idle;
    repeat (n) queue_pixel(rand_pixel());
    wait_idle();
  endtask

  initial begin
    int w;
    int h;
    int n;
    int idle;
    int random_px;
    int phase;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // two columns, height left at its reset value
    write_reg(mbd_pkg::REG_SOURCE_WIDTH, REG_BITS'(2));
    repeat (4) queue_pixel('0);
    repeat (2) queue_pixel('1);
    wait_idle();
    // write to a spare index must not restart the frame
    write_reg(REG_NONE, '1);
    repeat (2) queue_pixel('1);
    wait_idle();
    // restart in the middle of a block
    queue_pixel(32'h04030201);
    queue_pixel(32'hff00ff00);
    wait_idle();
    write_reg(mbd_pkg::REG_SOURCE_WIDTH, REG_BITS'(2));
    queue_pixel(32'h01010101);
    queue_pixel(32'h03010200);
    queue_pixel(32'h807f01ff);
    queue_pixel(32'h7f80fe00);
    wait_idle();
    run_image(0, 2, 3, 0);
    run_image(3, 3, 9, 0);

    // long output stall while the source keeps offering
    long_hold_req = 1'b1;
    run_image(4, 4, 200, 29);
    run_image(int'(REG_BITS'('1)), 2, 200, 29);
    run_image(2, MAX_DIM, 120, 0);

    random_px = pushed_px;
    phase     = 0;
    while (random_px < TOTAL_PX) begin
      phase++;
      w = ($urandom_range(9) == 0) ? $urandom_range(13, 80) : $urandom_range(0, 12);
      h = $urandom_range(0, 12);
      n = eff_dim(REG_BITS'(w)) * eff_dim(REG_BITS'(h)) * $urandom_range(1, 3) +
          $urandom_range(0, 20);
      if (n > 300) n = 300;
      idle = (phase % 5 == 2) ? 0 : 29;
      if ($urandom_range(3) == 0)
        write_reg(IDX_BITS'($urandom_range(int'(REG_NONE),
                                           int'(mbd_pkg::REG_SOURCE_HEIGHT) + 1)),
                  REG_BITS'($urandom));
      run_image(w, h, n, idle);
      random_px += n;
    end

    if (err_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
